// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising edge while out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// expression that must never be true while out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- rtl/lfcf_pkg.sv -----
// ----------------------------------------------------------------------------
// lfcf_pkg
// Shared widths, codes and control types of the damped comb filter
// ----------------------------------------------------------------------------
package lfcf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 17;
  localparam int COEF_FRAC   = 16;
  localparam int GUARD_W     = 8;
  localparam int STATE_W     = SAMPLE_W + GUARD_W;
  localparam int MUL_B_W     = COEF_W + 1;
  localparam int PROD_W      = STATE_W + MUL_B_W;
  localparam int MAX_DELAY   = 2048;
  localparam int ADDR_W      = $clog2(MAX_DELAY);
  localparam int LEN_W       = 12;
  localparam int DELAY_RESET = 1116;
  localparam int S_TDATA_W   = 72;
  localparam int M_TDATA_W   = 16;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC);

  // operation codes
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_DAMP,
    ST_MUL_FILT,
    ST_UPDATE,
    ST_MUL_REFL,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_DAMP,
    MUL_FILT,
    MUL_REFL
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic     latch_dly;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_state;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_op;
    logic out_free;
  } ctrl_sts_t;

endpackage

// ----- rtl/lowpass_feedback_comb_filter.sv -----
// ----------------------------------------------------------------------------
// lowpass_feedback_comb_filter
// Reverb comb filter with a one-pole lowpass in the feedback path
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// s_axis    in         tvalid / tready            tdata, tuser = operation, tlast
// m_axis    out        tvalid / tready            tdata = sample_out, tlast
// cfg       in         write enable, no wait      delay_length (12 bits)
//
// a sample goes read, damp multiply, filter multiply, state update, reflect multiply,
// finish, a clear read then finish; the one shared 24x18 multiplier is used three times per sample
// the result sits in an output register, so the next item is taken while it waits
// a stalled output only holds the sequencer at its final step
// reset zeroes the lowpass state and position and marks the store empty, so no
// clearing pass is needed; clear items and length changes do the same
//
module lowpass_feedback_comb_filter import lfcf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // sample_in [15:0], damping [32:16], reflection [49:33],
  // accumulate_in [65:50], zero [71:66]
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // operation
  input  logic                 s_axis_tuser_i,
  input  logic                 s_axis_tlast_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // sample_out [15:0]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tlast_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // delay length register
  input  logic                 cfg_we_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i
);

`include "assert_macros.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer
  lfcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, delay store and output register
  lfcf_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // one item in flight: an accept is never followed directly by another
  `ASSERT_PROP(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
  // a result is only loaded when the output register is free
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.finish && m_axis_tvalid_o && !m_axis_tready_i)
  // store read data is latched in the cycle after the read
  `ASSERT_PROP(a_read_then_latch, clk_i, rst_ni, cmd.rd_en |=> cmd.latch_dly)
  // a finished item always shows up at the output
  `ASSERT_PROP(a_finish_shows, clk_i, rst_ni, cmd.finish |=> m_axis_tvalid_o)

endmodule

// ----- rtl/lfcf_ram.sv -----
// ----------------------------------------------------------------------------
// lfcf_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module lfcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lfcf_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfcf_ctrl
// Sequencer that steps one item through read, three multiplies and writeback, a clear from read to finish
// ----------------------------------------------------------------------------
module lfcf_ctrl import lfcf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, rd_en: 1'b0, latch_dly: 1'b0, mul_en: 1'b0,
                   mul_sel: MUL_DAMP, upd_state: 1'b0, finish: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        if (sts_i.clear_op) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_MUL_DAMP;
        end
      end
      ST_MUL_DAMP: begin
        cmd_o.latch_dly = 1'b1;
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = MUL_DAMP;
        state_d         = ST_MUL_FILT;
      end
      ST_MUL_FILT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_FILT;
        state_d       = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.upd_state = 1'b1;
        state_d         = ST_MUL_REFL;
      end
      ST_MUL_REFL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_REFL;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lfcf_datapath.sv -----
// ----------------------------------------------------------------------------
// lfcf_datapath
// Item registers, shared multiplier, lowpass state, delay position and output
// ----------------------------------------------------------------------------
module lfcf_datapath import lfcf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o,
  input  logic                 in_op_i,
  input  logic [S_TDATA_W-1:0] in_data_i,
  input  logic                 in_last_i,
  input  logic                 cfg_we_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [M_TDATA_W-1:0] out_data_o,
  output logic                 out_last_o
);

  // input item fields
  logic signed [SAMPLE_W-1:0] f_sample;
  logic        [COEF_W-1:0]   f_damp, f_refl;
  logic signed [SAMPLE_W-1:0] f_acc;

  assign f_sample = in_data_i[SAMPLE_W-1:0];
  assign f_damp   = in_data_i[SAMPLE_W+COEF_W-1:SAMPLE_W];
  assign f_refl   = in_data_i[SAMPLE_W+2*COEF_W-1:SAMPLE_W+COEF_W];
  assign f_acc    = in_data_i[2*SAMPLE_W+2*COEF_W-1:SAMPLE_W+2*COEF_W];

  // captured item
  logic                       op_q, last_q;
  logic signed [SAMPLE_W-1:0] sample_q, acc_in_q;
  logic        [COEF_W-1:0]   damp_q, refl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_op_i;
      last_q   <= in_last_i;
      sample_q <= f_sample;
      acc_in_q <= f_acc;
      damp_q   <= (f_damp > COEF_ONE) ? COEF_ONE : f_damp;
      refl_q   <= (f_refl > COEF_ONE) ? COEF_ONE : f_refl;
    end
  end

  // control state: length, position, wrap flag, lowpass state
  logic [LEN_W-1:0]          len_q;
  logic [ADDR_W-1:0]         pos_q;
  logic                      wrapped_q;
  logic signed [STATE_W-1:0] lp_q;

  logic [LEN_W-1:0] len_eff;
  always_comb begin
    if (cfg_wdata_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg_wdata_i > LEN_W'(MAX_DELAY)) begin
      len_eff = LEN_W'(MAX_DELAY);
    end else begin
      len_eff = cfg_wdata_i;
    end
  end

  // delay store; entries read before the first full pass since a clear are zero
  logic                       ram_we;
  logic signed [SAMPLE_W-1:0] ram_wdata;
  logic        [SAMPLE_W-1:0] ram_rdata;

  lfcf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_DELAY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  logic signed [SAMPLE_W-1:0] dly_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_dly) begin
      dly_q <= wrapped_q ? signed'(ram_rdata) : '0;
    end
  end

  // shared multiplier, 24 x 18 signed
  logic signed [STATE_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_q, prev_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_FILT: begin
        mul_a = {dly_q, {GUARD_W{1'b0}}};
        mul_b = signed'({1'b0, COEF_ONE - damp_q});
      end
      MUL_REFL: begin
        mul_a = lp_q;
        mul_b = signed'({1'b0, refl_q});
      end
      default: begin
        mul_a = lp_q;
        mul_b = signed'({1'b0, damp_q});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
      prev_q <= prod_q;
    end
  end

  // new lowpass state: round half up, then clamp
  logic signed [PROD_W:0]          lp_sum;
  logic signed [PROD_W-COEF_FRAC:0] lp_rnd;
  logic signed [STATE_W-1:0]       lp_new;
  localparam logic signed [PROD_W-COEF_FRAC:0] LP_MAX =
    (PROD_W-COEF_FRAC+1)'((1 <<< (STATE_W-1)) - 1);
  localparam logic signed [PROD_W-COEF_FRAC:0] LP_MIN =
    (PROD_W-COEF_FRAC+1)'(-(1 <<< (STATE_W-1)));

  always_comb begin
    lp_sum = (PROD_W+1)'(prev_q) + (PROD_W+1)'(prod_q)
           + (PROD_W+1)'(1 <<< (COEF_FRAC-1));
    lp_rnd = lp_sum[PROD_W:COEF_FRAC];
    if (lp_rnd > LP_MAX) begin
      lp_new = STATE_W'(LP_MAX);
    end else if (lp_rnd < LP_MIN) begin
      lp_new = STATE_W'(LP_MIN);
    end else begin
      lp_new = lp_rnd[STATE_W-1:0];
    end
  end

  // feedback write value
  localparam int FB_SHIFT = COEF_FRAC + GUARD_W;
  localparam int FB_W     = PROD_W - FB_SHIFT;
  localparam logic signed [SAMPLE_W+2:0] S_MAX = (SAMPLE_W+3)'((1 <<< (SAMPLE_W-1)) - 1);
  localparam logic signed [SAMPLE_W+2:0] S_MIN = (SAMPLE_W+3)'(-(1 <<< (SAMPLE_W-1)));

  logic signed [PROD_W-1:0]   fb_full;
  logic signed [FB_W-1:0]     fb;
  logic signed [SAMPLE_W+2:0] wr_sum;
  logic signed [SAMPLE_W+2:0] out_sum;
  logic signed [SAMPLE_W-1:0] out_sat;

  always_comb begin
    fb_full = prod_q + PROD_W'(1 <<< (FB_SHIFT-1));
    fb      = fb_full[PROD_W-1:FB_SHIFT];
    wr_sum  = (SAMPLE_W+3)'(sample_q) + (SAMPLE_W+3)'(fb);
    if (wr_sum > S_MAX) begin
      ram_wdata = SAMPLE_W'(S_MAX);
    end else if (wr_sum < S_MIN) begin
      ram_wdata = SAMPLE_W'(S_MIN);
    end else begin
      ram_wdata = wr_sum[SAMPLE_W-1:0];
    end
    out_sum = (SAMPLE_W+3)'(acc_in_q) + (SAMPLE_W+3)'(dly_q);
    if (out_sum > S_MAX) begin
      out_sat = SAMPLE_W'(S_MAX);
    end else if (out_sum < S_MIN) begin
      out_sat = SAMPLE_W'(S_MIN);
    end else begin
      out_sat = out_sum[SAMPLE_W-1:0];
    end
  end

  assign ram_we = cmd_i.finish && (op_q == OP_PROCESS);

  logic [LEN_W-1:0] pos_inc;
  assign pos_inc = {1'b0, pos_q} + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= LEN_W'(DELAY_RESET);
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      lp_q      <= '0;
    end else if (cfg_we_i && (len_eff != len_q)) begin
      len_q     <= len_eff;
      pos_q     <= '0;
      wrapped_q <= 1'b0;
      lp_q      <= '0;
    end else if (cmd_i.upd_state) begin
      lp_q <= lp_new;
    end else if (cmd_i.finish) begin
      if (op_q == OP_CLEAR) begin
        pos_q     <= '0;
        wrapped_q <= 1'b0;
        lp_q      <= '0;
      end else if (pos_inc >= len_q) begin
        pos_q     <= '0;
        wrapped_q <= 1'b1;
      end else begin
        pos_q <= pos_inc[ADDR_W-1:0];
      end
    end
  end

  // output register
  logic                       out_valid_q;
  logic [M_TDATA_W-1:0]       out_data_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= (op_q == OP_CLEAR) ? '0 : M_TDATA_W'(out_sat);
      out_last_q <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_last_o     = out_last_q;
  assign sts_o.clear_op = (op_q == OP_CLEAR);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ----- tb/sv/lowpass_feedback_comb_filter_tb.sv -----
// ----------------------------------------------------------------------------
// lowpass_feedback_comb_filter_tb
// Self-checking bench for the damped feedback comb filter: a queue-fed stream
// driver with random gaps, a scoreboard fed by a bit-exact model of the delay
// store and lowpass state, and a sink with random and long back-pressure,
// run across several delay lengths including the extremes
// ----------------------------------------------------------------------------
module lowpass_feedback_comb_filter_tb;
  import lfcf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 16;    // pause after the last result
  localparam int HOLD_CYCLES = 400;   // long sink hold-off that backs up the input

  // one input item as the filter sees it
  typedef struct {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic        [COEF_W-1:0]   damping;
    logic        [COEF_W-1:0]   reflection;
    logic signed [SAMPLE_W-1:0] accum;
    logic                       block_end;
  } comb_in_t;

  // one result item
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic                block_end;
  } comb_out_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                 s_axis_tuser_i = 1'b0;
  logic                 s_axis_tlast_i = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [LEN_W-1:0]     cfg_wdata_i = '0;

  // model state of the filter
  logic signed [SAMPLE_W-1:0] dly_mem [MAX_DELAY];
  logic signed [STATE_W-1:0]  lp_state;
  logic        [LEN_W-1:0]    wr_pos;
  logic        [LEN_W-1:0]    cur_len;

  comb_in_t  pending_in[$];    // items waiting to be offered
  comb_out_t expected_out[$];  // predicted results in order
  comb_in_t  cur_item;
  comb_out_t mon_want;

  logic drv_active = 1'b0;
  logic drv_taken = 1'b0;
  logic src_lazy = 1'b1;
  int   drv_gap = 0;
  logic rcv_taken = 1'b0;
  logic rcv_open = 1'b1;
  logic sink_lazy = 1'b1;
  int   rcv_stall = 0;
  int   hold_left = 0;

  int items_taken = 0;
  int clears_taken = 0;
  int results_seen = 0;
  int lengths_written = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  lowpass_feedback_comb_filter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // filter model
  // --------------------------------------------------------------------------

  function automatic longint saturate(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // floor(v / 2^s + 1/2)
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void comb_clear();
    for (int i = 0; i < MAX_DELAY; i++) dly_mem[i] = '0;
    lp_state = '0;
    wr_pos   = '0;
  endfunction

  // 0 means 1, anything past the store means the whole store
  function automatic logic [LEN_W-1:0] clip_length(logic [LEN_W-1:0] v);
    if (v == '0) return LEN_W'(1);
    if (v > LEN_W'(MAX_DELAY)) return LEN_W'(MAX_DELAY);
    return v;
  endfunction

  function automatic comb_out_t comb_predict(comb_in_t it);
    comb_out_t r;
    longint    one, dly, dmp, rfl, fb, wr, nxt;
    one = longint'(COEF_ONE);
    r.block_end = it.block_end;
    if (it.op == OP_CLEAR) begin
      comb_clear();
      r.sample = '0;
      return r;
    end
    // coefficients above one act as one
    dmp = (it.damping > COEF_ONE) ? one : longint'(it.damping);
    rfl = (it.reflection > COEF_ONE) ? one : longint'(it.reflection);
    if (wr_pos >= cur_len) wr_pos = '0;
    dly = longint'(dly_mem[wr_pos]);
    // lowpass keeps 8 guard bits below the sample lsb
    nxt = round_half_up(dly * 256 * (one - dmp) + longint'(lp_state) * dmp, COEF_FRAC);
    lp_state = STATE_W'(saturate(nxt, STATE_W));
    fb = round_half_up(longint'(lp_state) * rfl, COEF_FRAC + GUARD_W);
    wr = saturate(longint'(it.sample) + fb, SAMPLE_W);
    dly_mem[wr_pos] = SAMPLE_W'(wr);
    wr_pos = wr_pos + 1'b1;
    if (wr_pos >= cur_len) wr_pos = '0;
    r.sample = SAMPLE_W'(saturate(longint'(it.accum) + dly, SAMPLE_W));
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_ONE;
      1:       return '0;
      2:       return COEF_W'($urandom);                  // may exceed one
      3, 4:    return COEF_W'($urandom_range(56000, 65536)); // strong feedback
      default: return COEF_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return {1'b0, {(SAMPLE_W-1){1'b1}}};
      1:       return {1'b1, {(SAMPLE_W-1){1'b0}}};
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic push_item(logic op, logic [SAMPLE_W-1:0] s, logic [COEF_W-1:0] d,
                           logic [COEF_W-1:0] r, logic [SAMPLE_W-1:0] a, logic l);
    comb_in_t it;
    it.op         = op;
    it.sample     = s;
    it.damping    = d;
    it.reflection = r;
    it.accum      = a;
    it.block_end  = l;
    pending_in.push_back(it);
  endtask

  task automatic push_random(int n);
    logic op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_PROCESS;
      push_item(op, rand_sample(), rand_coef(), rand_coef(), rand_sample(),
                1'($urandom));
    end
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (pending_in.size() != 0 || drv_active || expected_out.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_delay_length(logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] eff;
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    // only a real change of length clears
    eff = clip_length(v);
    if (eff != cur_len) begin
      cur_len = eff;
      comb_clear();
    end
    lengths_written++;
  endtask

  // --------------------------------------------------------------------------
  // source driver: takes items from the pending queue, drives at falling edge
  // --------------------------------------------------------------------------

  // accept seen at the rising edge, handled at the next falling edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) drv_taken = 1'b1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (drv_taken) begin
        drv_taken  = 1'b0;
        drv_active = 1'b0;
        expected_out.push_back(comb_predict(cur_item));
        items_taken++;
        if (cur_item.op == OP_CLEAR) clears_taken++;
        // switch now and then between gappy and back-to-back stretches
        if ($urandom_range(0, 31) == 0) src_lazy = !src_lazy;
        drv_gap = src_lazy ? $urandom_range(0, 16) : 0;
      end
      if (!drv_active) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (pending_in.size() != 0) begin
          cur_item   = pending_in.pop_front();
          drv_active = 1'b1;
        end
      end
    end
    // one nonblocking write per signal per edge keeps valid steady between items
    s_axis_tvalid_i <= drv_active;
    s_axis_tdata_i  <= S_TDATA_W'({cur_item.accum, cur_item.reflection,
                                   cur_item.damping, cur_item.sample});
    s_axis_tuser_i  <= cur_item.op;
    s_axis_tlast_i  <= cur_item.block_end;
  end

  // --------------------------------------------------------------------------
  // sink: random stalls per item plus an occasional long hold-off
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rcv_taken) begin
        rcv_taken = 1'b0;
        if ($urandom_range(0, 31) == 0) sink_lazy = !sink_lazy;
        rcv_stall = sink_lazy ? $urandom_range(0, 16) : 0;
      end
      rcv_open = (rcv_stall == 0);
      if (rcv_stall != 0) rcv_stall--;
    end
    m_axis_tready_i <= rst_ni && rcv_open && (hold_left == 0);
  end

  // --------------------------------------------------------------------------
  // monitor: compare each result with the oldest prediction
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      rcv_taken = 1'b1;
      results_seen++;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: sample %h last %b",
                   m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        mon_want = expected_out.pop_front();
        if (m_axis_tdata_o !== mon_want.sample || m_axis_tlast_o !== mon_want.block_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: sample exp %h got %h, last exp %b got %b",
                     results_seen, mon_want.sample, m_axis_tdata_o,
                     mon_want.block_end, m_axis_tlast_o);
        end
      end
    end
  end

  // run time limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_out.size());
      $display("lowpass_feedback_comb_filter_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------

  initial begin
    comb_clear();
    cur_len = LEN_W'(DELAY_RESET);
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset length, no write yet
    push_random(40);

    // short delay so feedback shows up within a few items
    set_delay_length(LEN_W'(3));
    push_item(OP_PROCESS, 16'h7fff, 17'h00000, 17'h10000, 16'h0000, 1'b0);
    push_item(OP_PROCESS, 16'h8000, 17'h10000, 17'h00000, 16'h7fff, 1'b1);
    // coefficients above one
    push_item(OP_PROCESS, 16'h0000, 17'h1ffff, 17'h1ffff, 16'h8000, 1'b0);
    // delayed full scale, output sum and store write both saturate high
    push_item(OP_PROCESS, 16'h7fff, 17'h00000, 17'h10000, 16'h7fff, 1'b0);
    // same toward the negative rail
    push_item(OP_PROCESS, 16'h8000, 17'h00000, 17'h10000, 16'h8000, 1'b1);
    push_item(OP_PROCESS, 16'h0000, 17'h10000, 17'h18000, 16'h0000, 1'b0);
    push_item(OP_PROCESS, 16'h7fff, 17'h0ffff, 17'h0ffff, 16'h7fff, 1'b0);
    push_item(OP_PROCESS, 16'h8000, 17'h00001, 17'h00001, 16'h8000, 1'b1);
    // clear: zero result, mark still copied
    push_item(OP_CLEAR,   16'hffff, 17'h1ffff, 17'h1ffff, 16'hffff, 1'b1);
    push_item(OP_PROCESS, 16'h0001, 17'h00001, 17'h00001, 16'hffff, 1'b0);
    push_item(OP_PROCESS, 16'hffff, 17'h0ffff, 17'h0ffff, 16'h0001, 1'b0);
    push_item(OP_PROCESS, 16'h3039, 17'h08000, 17'h08000, 16'hcfc7, 1'b1);
    push_item(OP_PROCESS, 16'h5555, 17'h15555, 17'h0aaaa, 16'haaaa, 1'b0);
    push_item(OP_PROCESS, 16'haaaa, 17'h0aaaa, 17'h15555, 16'h5555, 1'b1);
    push_item(OP_CLEAR,   16'h0000, 17'h00000, 17'h00000, 16'h0000, 1'b0);
    push_item(OP_PROCESS, 16'h4000, 17'h10001, 17'h10001, 16'hc000, 1'b0);
    push_item(OP_PROCESS, 16'h7fff, 17'h00000, 17'h10000, 16'h0000, 1'b0);
    push_item(OP_PROCESS, 16'h7fff, 17'h00000, 17'h10000, 16'h0000, 1'b0);
    push_item(OP_PROCESS, 16'h7fff, 17'h00000, 17'h10000, 16'h0000, 1'b1);
    push_item(OP_PROCESS, 16'h0000, 17'h0c000, 17'h0f000, 16'h0000, 1'b0);
    push_random(150);

    // same length again: state must survive
    set_delay_length(LEN_W'(3));
    push_random(60);

    // zero counts as one
    set_delay_length(LEN_W'(0));
    push_random(150);
    set_delay_length(LEN_W'(1));
    push_random(40);

    // past the store counts as the full store
    set_delay_length({LEN_W{1'b1}});
    push_random(100);
    set_delay_length(LEN_W'(MAX_DELAY));
    push_random(40);

    // long sink hold-off while the source keeps offering
    set_delay_length(LEN_W'(17));
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    push_random(200);

    set_delay_length(LEN_W'(2));
    push_random(150);

    set_delay_length(LEN_W'($urandom_range(4, 64)));
    push_random(100);

    // back to the reset length, more items than the delay holds, with random clears among them
    set_delay_length(LEN_W'(DELAY_RESET));
    push_random(1150);

    wait_idle();
    $display("covered %0d items (%0d clears) and %0d results over %0d length writes",
             items_taken, clears_taken, results_seen, lengths_written);
    $display("result mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("lowpass_feedback_comb_filter_tb OK");
    end else begin
      $display("lowpass_feedback_comb_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- lowpass_feedback_comb_filter.f -----
+incdir+rtl
rtl/lfcf_pkg.sv
rtl/lfcf_ram.sv
rtl/lfcf_ctrl.sv
rtl/lfcf_datapath.sv
rtl/lowpass_feedback_comb_filter.sv
tb/sv/lowpass_feedback_comb_filter_tb.sv
